// ----- hdl/rmbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rmbs_pkg
// Shared types and constants for the running-mean background subtractor.
// ----------------------------------------------------------------------------
package rmbs_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 4096;
  localparam int ROW_W       = 8;
  localparam int COL_W       = 12;
  localparam int RCFG_W      = 9;
  localparam int PIX_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int MEAN_W      = 32;
  localparam int PROD_W      = 48;
  localparam int Z_W         = 38;
  localparam int MAG_W       = 38;
  localparam int DIV_STAGES  = MAG_W / 2;
  localparam int CIDX_W      = 8;
  localparam int CDATA_W     = 16;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ROWS_USED = 8'd0,
    CFG_GAIN      = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             clipped;
  } out_t;

endpackage

// ----- hdl/running_mean_background_subtract.sv -----
// ----------------------------------------------------------------------------
// running_mean_background_subtract
// Per-row running-mean background subtraction for a column-major pixel stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_data  (pixel_in, frame_start)
//  out_    | output    | out_valid/out_ready  | out_data (pixel_out, clipped)
//  cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One pixel per cycle unless stalled; 23 register stages from input transfer to output.
// The mean update runs through a 19-stage radix-4 divider; a pixel whose row
// mean is still in flight waits, so fewer rows than pipeline depth slow it.
// A frame start waits until no mean write is pending.
// A stalled output freezes the whole pipeline. Reset: rows_used 256, gain 1.0.
module running_mean_background_subtract (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rmbs_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rmbs_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmbs_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rmbs_pkg::CDATA_W-1:0]   cfg_data
);

  localparam int N = rmbs_pkg::DIV_STAGES;

  typedef struct packed {
    logic [rmbs_pkg::PIX_W-1:0] pixel;
    logic [rmbs_pkg::ROW_W-1:0] row;
    logic [rmbs_pkg::COL_W-1:0] col;
    logic                       wen;
  } s0_t;

  typedef struct packed {
    logic [rmbs_pkg::PIX_W-1:0]         pixel;
    logic [rmbs_pkg::ROW_W-1:0]         row;
    logic [rmbs_pkg::COL_W-1:0]         col;
    logic                               wen;
    logic signed [rmbs_pkg::MEAN_W-1:0] mean;
    logic signed [rmbs_pkg::PROD_W-1:0] prod;
  } s1_t;

  typedef struct packed {
    logic [rmbs_pkg::ROW_W-1:0]         row;
    logic [rmbs_pkg::COL_W-1:0]         col;
    logic                               wen;
    logic signed [rmbs_pkg::MEAN_W-1:0] mean;
    logic [rmbs_pkg::PIX_W-1:0]         res;
    logic                               clip;
    logic                               neg;
    logic [rmbs_pkg::COL_W-1:0]         rem;
    logic [rmbs_pkg::MAG_W-1:0]         quo;
  } dv_t;

  function automatic dv_t div_step(input dv_t a);
    dv_t                        b;
    logic [rmbs_pkg::COL_W:0]   t;
    b = a;
    for (int i = 0; i < 2; i++) begin
      t = {b.rem, b.quo[rmbs_pkg::MAG_W-1]};
      if (t >= {1'b0, b.col}) begin
        t     = t - {1'b0, b.col};
        b.quo = {b.quo[rmbs_pkg::MAG_W-2:0], 1'b1};
      end else begin
        b.quo = {b.quo[rmbs_pkg::MAG_W-2:0], 1'b0};
      end
      b.rem = t[rmbs_pkg::COL_W-1:0];
    end
    return b;
  endfunction

  logic [rmbs_pkg::RCFG_W-1:0]          rows_used_r;
  logic [rmbs_pkg::GAIN_W-1:0]          gain_r;
  logic [rmbs_pkg::ROW_W-1:0]           row_idx_r;
  logic [rmbs_pkg::COL_W-1:0]           col_idx_r;
  logic [rmbs_pkg::MAX_ROWS-1:0]        mvalid_r;
  logic signed [rmbs_pkg::MEAN_W-1:0]   mem [rmbs_pkg::MAX_ROWS];
  logic signed [rmbs_pkg::MEAN_W-1:0]   mrd_r;
  logic                                 mvld_r;
  logic                                 s0_vld_r;
  s0_t                                  s0_r;
  logic                                 s1_vld_r;
  s1_t                                  s1_r;
  logic                                 dv_vld_r [N+1];
  dv_t                                  dv_r [N+1];
  logic                                 out_valid_r;
  rmbs_pkg::out_t                       out_r;

  logic                                 en;
  logic                                 in_xfer;
  logic [rmbs_pkg::RCFG_W-1:0]          rows_eff;
  logic [rmbs_pkg::ROW_W-1:0]           row_cur;
  logic [rmbs_pkg::COL_W-1:0]           col_cur;
  logic [rmbs_pkg::RCFG_W-1:0]          row_inc;
  logic [rmbs_pkg::ROW_W-1:0]           row_idx_nxt;
  logic [rmbs_pkg::COL_W-1:0]           col_idx_nxt;
  logic                                 row_hit;
  logic                                 pend_any;
  logic signed [rmbs_pkg::MEAN_W-1:0]   s1_mean;
  logic signed [rmbs_pkg::PROD_W-1:0]   bg_sum;
  logic signed [rmbs_pkg::Z_W-1:0]      z;
  logic signed [rmbs_pkg::Z_W-1:0]      dif;
  logic [rmbs_pkg::Z_W-1:0]             zr;
  dv_t                                  dv0_nxt;
  logic signed [rmbs_pkg::MAG_W:0]      qs;
  logic signed [rmbs_pkg::MAG_W+1:0]    nm;
  logic signed [rmbs_pkg::MEAN_W-1:0]   nm_sat;
  logic                                 wr_en;

  assign en        = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (rows_used_r == '0) begin
      rows_eff = rmbs_pkg::RCFG_W'(1);
    end else if (rows_used_r > rmbs_pkg::RCFG_W'(rmbs_pkg::MAX_ROWS)) begin
      rows_eff = rmbs_pkg::RCFG_W'(rmbs_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_used_r;
    end
    row_cur = in_data.frame_start ? '0 : row_idx_r;
    col_cur = in_data.frame_start ? '0 : col_idx_r;
    row_inc = {1'b0, row_cur} + rmbs_pkg::RCFG_W'(1);
    if (row_inc >= rows_eff) begin
      row_idx_nxt = '0;
      col_idx_nxt = (col_cur < rmbs_pkg::COL_W'(rmbs_pkg::MAX_COLUMNS - 1)) ?
                    col_cur + rmbs_pkg::COL_W'(1) : col_cur;
    end else begin
      row_idx_nxt = row_inc[rmbs_pkg::ROW_W-1:0];
      col_idx_nxt = col_cur;
    end
  end

  always_comb begin
    row_hit  = (s0_vld_r && s0_r.wen && s0_r.row == row_cur) ||
               (s1_vld_r && s1_r.wen && s1_r.row == row_cur);
    pend_any = (s0_vld_r && s0_r.wen) || (s1_vld_r && s1_r.wen);
    for (int k = 0; k <= N; k++) begin
      if (dv_vld_r[k] && dv_r[k].wen) begin
        pend_any = 1'b1;
        if (dv_r[k].row == row_cur) begin
          row_hit = 1'b1;
        end
      end
    end
  end

  assign in_ready = en && !(in_data.frame_start ? pend_any : row_hit);
  assign in_xfer  = in_valid && in_ready;

  // background, residual and output pixel
  always_comb begin
    s1_mean = mvld_r ? mrd_r : '0;
    bg_sum  = s1_r.prod + rmbs_pkg::PROD_W'(2048);
    z       = $signed({14'd0, s1_r.pixel, 8'd0}) - rmbs_pkg::Z_W'(bg_sum >>> 12);
    dif     = z - rmbs_pkg::Z_W'(s1_r.mean);
    zr      = z + rmbs_pkg::Z_W'(128);
    dv0_nxt      = '0;
    dv0_nxt.row  = s1_r.row;
    dv0_nxt.col  = s1_r.col;
    dv0_nxt.wen  = s1_r.wen;
    dv0_nxt.mean = s1_r.mean;
    dv0_nxt.neg  = dif < 0;
    dv0_nxt.quo  = (dif < 0) ? rmbs_pkg::MAG_W'(-dif) : rmbs_pkg::MAG_W'(dif);
    if (!s1_r.wen) begin
      dv0_nxt.res = s1_r.pixel;
    end else if (z >= rmbs_pkg::Z_W'(16777088)) begin
      dv0_nxt.res  = '1;
      dv0_nxt.clip = 1'b1;
    end else if (z > 0) begin
      dv0_nxt.res = zr[23:8];
    end
  end

  // mean update from the last divider stage
  always_comb begin
    qs = dv_r[N].neg ? -$signed({1'b0, dv_r[N].quo}) : $signed({1'b0, dv_r[N].quo});
    nm = rmbs_pkg::MAG_W'(0) + (rmbs_pkg::MAG_W+2)'(dv_r[N].mean) +
         (rmbs_pkg::MAG_W+2)'(qs);
    if (nm > (rmbs_pkg::MAG_W+2)'(64'sh7FFF_FFFF)) begin
      nm_sat = 32'sh7FFF_FFFF;
    end else if (nm < -(rmbs_pkg::MAG_W+2)'(64'sh8000_0000)) begin
      nm_sat = 32'sh8000_0000;
    end else begin
      nm_sat = nm[rmbs_pkg::MEAN_W-1:0];
    end
    wr_en = en && dv_vld_r[N] && dv_r[N].wen;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[dv_r[N].row] <= nm_sat;
    end
    if (en) begin
      mrd_r <= mem[row_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= rmbs_pkg::RCFG_W'(rmbs_pkg::MAX_ROWS);
      gain_r      <= rmbs_pkg::GAIN_W'(4096);
      row_idx_r   <= '0;
      col_idx_r   <= '0;
      mvalid_r    <= '0;
      mvld_r      <= 1'b0;
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= N; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rmbs_pkg::CFG_ROWS_USED: rows_used_r <= cfg_data[rmbs_pkg::RCFG_W-1:0];
          rmbs_pkg::CFG_GAIN:      gain_r      <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        row_idx_r <= row_idx_nxt;
        col_idx_r <= col_idx_nxt;
        if (in_data.frame_start) begin
          mvalid_r <= '0;
        end
      end
      if (wr_en) begin
        mvalid_r[dv_r[N].row] <= 1'b1;
      end
      if (en) begin
        mvld_r      <= mvalid_r[row_cur] && !in_data.frame_start;
        s0_vld_r    <= in_xfer;
        s1_vld_r    <= s0_vld_r;
        dv_vld_r[0] <= s1_vld_r;
        for (int k = 0; k < N; k++) begin
          dv_vld_r[k+1] <= dv_vld_r[k];
        end
        out_valid_r <= dv_vld_r[N];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.pixel <= in_data.pixel_in;
      s0_r.row   <= row_cur;
      s0_r.col   <= col_cur;
      s0_r.wen   <= col_cur != '0;
      s1_r.pixel <= s0_r.pixel;
      s1_r.row   <= s0_r.row;
      s1_r.col   <= s0_r.col;
      s1_r.wen   <= s0_r.wen;
      s1_r.mean  <= s1_mean;
      s1_r.prod  <= rmbs_pkg::PROD_W'($signed({1'b0, gain_r}) * s1_mean);
      dv_r[0]    <= dv0_nxt;
      for (int k = 0; k < N; k++) begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
      out_r.pixel_out <= dv_r[N].res;
      out_r.clipped   <= dv_r[N].clip;
    end
  end

`ifndef SYNTH
  a_fs_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.frame_start) |-> !pend_any)
    else $error("frame start taken with mean write pending");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.clipped) |-> (out_r.pixel_out == '1))
    else $error("clipped without saturated pixel");

  a_pipe_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s1_vld_r) |=> dv_vld_r[0])
    else $error("item lost between stage 1 and divider");
`endif

endmodule
